// ===== src/hsp_pkg.sv =====
// Package for the periodic 1-D heat stencil: field widths, register indexes,
// reset values and the job record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package hsp_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int IDX_W      = 6;
  localparam int LEN_W      = 7;
  localparam int STEP_W     = 16;
  localparam int COEFF_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_COEFF = 2'd2;

  localparam logic [LEN_W-1:0]   GRID_LENGTH_RST = 7'd20;
  localparam logic [LEN_W-1:0]   MIN_POINTS      = 7'd3;
  localparam logic [STEP_W-1:0]  STEP_COUNT_RST  = 16'd1;
  localparam logic [COEFF_W-1:0] COEFF_RST       = 16'd26214;

  // One accepted sample, tagged with where it goes and, on the sample that
  // completes the ring, the run settings in force at that moment.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           addr;
    logic                       complete;
    logic [LEN_W-1:0]           n;
    logic [COEFF_W-1:0]         coeff;
    logic [STEP_W-1:0]          steps;
  } job_t;

endpackage

`default_nettype wire

// ===== src/hsp_stream_if.sv =====
// Valid/ready stream interfaces for the heat stencil: sample input and
// point result output. Depends on hsp_pkg.
`default_nettype none

interface hsp_in_if;
  import hsp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hsp_out_if;
  import hsp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] value;
  logic [IDX_W-1:0]           point_index;
  logic                       last;

  modport source (output valid, output value, output point_index, output last, input ready);
  modport sink   (input valid, input value, input point_index, input last, output ready);
endinterface

`default_nettype wire

// ===== src/heat_stencil_1d_periodic.sv =====
// Periodic 1-D explicit heat stencil: load a ring of n samples, run the steps, stream it out.
// Samples are taken whenever the queue has room. A time step reads the ring plus a wrap
// point at each end through a multiply/saturate pipe; results leave one at a time.
// Throughput is set by the single read port of the ping-pong RAM pair and the step loop.
// Reset: synchronous, clears control state and loads the register defaults; RAMs are not cleared.
// Depends on hsp_pkg, hsp_stream_if, hsp_front, hsp_queue, hsp_back, hsp_ram.
`default_nettype none

module heat_stencil_1d_periodic #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  hsp_in_if.sink                               din,
  hsp_out_if.source                            dout,
  input  wire logic                            cfg_we,
  input  wire logic [hsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hsp_pkg::*;

  // Configuration registers, to be written by the user only while the block is idle
  // (the block itself does not enforce this); the front end samples them straight into each job record.
  logic [LEN_W-1:0]   grid_length;
  logic [STEP_W-1:0]  step_count;
  logic [COEFF_W-1:0] diffusion_coeff;

  // Front end to queue, queue to back end.
  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_length     <= GRID_LENGTH_RST;
      step_count      <= STEP_COUNT_RST;
      diffusion_coeff <= COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_LENGTH:     grid_length     <= cfg_data[LEN_W-1:0];
        REG_STEP_COUNT:      step_count      <= cfg_data[STEP_W-1:0];
        REG_DIFFUSION_COEFF: diffusion_coeff <= cfg_data[COEFF_W-1:0];
        default: begin
          // Unmapped index: drop the write.
        end
      endcase
    end
  end

  // Front end: take a sample each cycle the queue has room, tag it with its
  // ring slot and, on the completing sample, the clamped length, coefficient
  // and step count.
  hsp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .din             (din),
    .grid_length     (grid_length),
    .step_count      (step_count),
    .diffusion_coeff (diffusion_coeff),
    .push_job        (push_job),
    .push_valid      (push_valid),
    .push_ready      (push_ready)
  );

  // Two-entry queue: lets the front take up to two more samples while the back end
  // is busy stepping or waiting on the result channel.
  hsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Back end: write samples into the current bank; on a completing sample,
  // sweep every step from one bank into the other, then stream the final
  // bank out through a result register with last on the final point.
  hsp_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .dout      (dout)
  );

endmodule

`default_nettype wire

// ===== src/hsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/hsp_front.sv =====
// Front end: accepts samples, assigns each a ring slot and flags the sample
// that completes the ring. Depends on hsp_pkg and hsp_stream_if.
`default_nettype none

module hsp_front #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  hsp_in_if.sink                             din,
  input  wire logic [hsp_pkg::LEN_W-1:0]     grid_length,
  input  wire logic [hsp_pkg::STEP_W-1:0]    step_count,
  input  wire logic [hsp_pkg::COEFF_W-1:0]   diffusion_coeff,
  output      hsp_pkg::job_t                 push_job,
  output      logic                          push_valid,
  input  wire logic                          push_ready
);
  import hsp_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0]    load_count;
  logic [CW-1:0]    cnt_inc;
  logic [LEN_W-1:0] n_clamp;
  logic             complete;

  always_comb begin
    if (grid_length < MIN_POINTS) begin
      n_clamp = MIN_POINTS;
    end else if (grid_length > LEN_W'(MAX_POINTS)) begin
      n_clamp = LEN_W'(MAX_POINTS);
    end else begin
      n_clamp = grid_length;
    end
  end

  assign cnt_inc  = load_count + 1'b1;
  assign complete = LEN_W'(cnt_inc) >= n_clamp;

  assign din.ready  = push_ready;
  assign push_valid = din.valid;

  always_comb begin
    push_job.sample   = din.sample;
    push_job.addr     = IDX_W'(load_count[AW-1:0]);
    push_job.complete = complete;
    push_job.n        = n_clamp;
    push_job.coeff    = diffusion_coeff;
    push_job.steps    = step_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (din.valid && push_ready) begin
      load_count <= complete ? '0 : cnt_inc;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsp_queue.sv =====
// Two-entry job queue between front end and back end.
// Depends on hsp_pkg.
`default_nettype none

module hsp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hsp_pkg::job_t push_job,
  input  wire logic          push_valid,
  output      logic          push_ready,
  output      hsp_pkg::job_t pop_job,
  output      logic          pop_valid,
  input  wire logic          pop_ready
);
  import hsp_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  job_t          slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != NW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hsp_back.sv =====
// Back end: stores samples, sweeps the diffusion steps over two ping-pong
// RAMs and streams the ring out. Depends on hsp_pkg, hsp_stream_if, hsp_ram.
`default_nettype none

module hsp_back #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hsp_pkg::job_t pop_job,
  input  wire logic          pop_valid,
  output      logic          pop_ready,
  hsp_out_if.source          dout
);
  import hsp_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(MAX_POINTS + 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

  logic [1:0]         state;
  logic               bank;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      n_last;
  logic [COEFF_W-1:0] c_r;
  logic [STEP_W-1:0]  steps_left;

  // step sweep
  logic [KW-1:0]             k;
  logic                      issue_done;
  logic                      step_issue;
  logic [AW-1:0]             step_addr;
  logic                      v1;
  logic [KW-1:0]             k1;
  logic                      v2;
  logic [KW-1:0]             k2;
  logic signed [SAMPLE_W-1:0] w0;
  logic signed [SAMPLE_W-1:0] w1;
  logic signed [SAMPLE_W-1:0] w2;
  logic signed [33:0]        lap;
  logic signed [50:0]        mul_full;
  logic                      v3;
  logic [AW-1:0]             i3;
  logic signed [SAMPLE_W-1:0] u3;
  logic signed [49:0]        prod;
  logic signed [33:0]        inc;
  logic signed [34:0]        sum;
  logic signed [SAMPLE_W-1:0] new_val;

  // emission
  logic [CW-1:0]              e_cnt;
  logic                       inflight;
  logic                       emit_issue;
  logic [AW-1:0]              e_idx;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_value;
  logic [IDX_W-1:0]           out_index;
  logic                       out_last;

  // memories
  logic                load_wr;
  logic                wr_en;
  logic                wr_bank;
  logic [AW-1:0]       waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic [AW-1:0]       raddr;
  logic [SAMPLE_W-1:0] rdata0;
  logic [SAMPLE_W-1:0] rdata1;
  logic signed [SAMPLE_W-1:0] rdata;

  assign pop_ready = state == ST_IDLE;
  assign load_wr   = (state == ST_IDLE) && pop_valid;
  assign n_last    = n_r - 1'b1;

  // Read order per step: u[n-1], u[0] .. u[n-1], u[0].
  assign step_issue = (state == ST_STEP) && !issue_done;
  always_comb begin
    if (k == '0) begin
      step_addr = AW'(n_last);
    end else if (k == (KW'(n_r) + 1'b1)) begin
      step_addr = '0;
    end else begin
      step_addr = AW'(k - 1'b1);
    end
  end

  assign emit_issue = (state == ST_EMIT) && !inflight && (e_cnt < n_r)
                      && (!out_valid || dout.ready);

  assign raddr = (state == ST_STEP) ? step_addr : AW'(e_cnt);
  assign rdata = bank ? rdata1 : rdata0;

  // Stencil arithmetic: exact Laplacian, product, floor shift, saturating add.
  assign lap      = 34'(w0) + 34'(w2) - (34'(w1) <<< 1);
  assign mul_full = lap * $signed({1'b0, c_r});
  assign inc      = prod[49:16];
  assign sum      = 35'(u3) + 35'(inc);

  always_comb begin
    if (sum > SAT_HI) begin
      new_val = SAT_HI[SAMPLE_W-1:0];
    end else if (sum < SAT_LO) begin
      new_val = SAT_LO[SAMPLE_W-1:0];
    end else begin
      new_val = sum[SAMPLE_W-1:0];
    end
  end

  assign wr_en   = load_wr || v3;
  assign wr_bank = load_wr ? bank : ~bank;
  assign waddr   = load_wr ? pop_job.addr[AW-1:0] : i3;
  assign wdata   = load_wr ? pop_job.sample : new_val;

  hsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_POINTS)) u_ram0 (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata0)
  );

  hsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_POINTS)) u_ram1 (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    k1 <= k;
    k2 <= k1;
    if (v1) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= rdata;
    end
    i3   <= AW'(k2 - KW'(2));
    u3   <= w1;
    prod <= mul_full[49:0];
    if (emit_issue) begin
      e_idx <= AW'(e_cnt);
    end
    if (inflight) begin
      out_value <= rdata;
      out_index <= IDX_W'(e_idx);
      out_last  <= e_idx == AW'(n_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bank       <= 1'b0;
      n_r        <= '0;
      c_r        <= '0;
      steps_left <= '0;
      k          <= '0;
      issue_done <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      e_cnt      <= '0;
      inflight   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      v1 <= step_issue;
      v2 <= v1;
      v3 <= v2 && (k2 >= KW'(2));
      if (step_issue) begin
        k <= k + 1'b1;
        if (k == (KW'(n_r) + 1'b1)) begin
          issue_done <= 1'b1;
        end
      end
      if (dout.valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_issue) begin
        inflight <= 1'b1;
        e_cnt    <= e_cnt + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (pop_valid && pop_job.complete) begin
            n_r        <= CW'(pop_job.n);
            c_r        <= pop_job.coeff;
            steps_left <= pop_job.steps;
            k          <= '0;
            issue_done <= 1'b0;
            e_cnt      <= '0;
            state      <= (pop_job.steps == '0) ? ST_EMIT : ST_STEP;
          end
        end
        ST_STEP: begin
          if (v3 && (i3 == AW'(n_last))) begin
            bank       <= ~bank;
            steps_left <= steps_left - 1'b1;
            if (steps_left == STEP_W'(1)) begin
              state <= ST_EMIT;
            end else begin
              k          <= '0;
              issue_done <= 1'b0;
            end
          end
        end
        ST_EMIT: begin
          if (inflight) begin
            inflight  <= 1'b0;
            out_valid <= 1'b1;
            if (e_idx == AW'(n_last)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign dout.valid       = out_valid;
  assign dout.value       = out_value;
  assign dout.point_index = out_index;
  assign dout.last        = out_last;

endmodule

`default_nettype wire

// ===== src/hsp_checker.sv =====
// Port-level checker for heat_stencil_1d_periodic and its bind statement.
// Depends on hsp_pkg.
`default_nettype none

module hsp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [hsp_pkg::SAMPLE_W-1:0] out_value,
  input wire logic [hsp_pkg::IDX_W-1:0]    out_index,
  input wire logic                         out_last
);
  import hsp_pkg::*;

  logic [IDX_W-1:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx <= out_last ? '0 : exp_idx + 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
                                && $stable(out_index) && $stable(out_last))
    else $error("stalled result changed");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_index == exp_idx)
    else $error("result out of index order");

  a_last_min_ring: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_index >= IDX_W'(2))
    else $error("ring closed with fewer than three points");

endmodule

bind heat_stencil_1d_periodic hsp_checker u_hsp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_value (dout.value),
  .out_index (dout.point_index),
  .out_last  (dout.last)
);

`default_nettype wire

// ===== tb/sv/hsp_ring_checker.sv =====
// Result checker for heat_stencil_1d_periodic. It watches the sample and point
// channels and the register write port, predicts every grid point and compares.
// Depends on hsp_pkg and hsp_stream_if.
module hsp_ring_checker #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  hsp_in_if                                   din,
  hsp_out_if                                  dout,
  input  wire logic                           cfg_we,
  input  wire logic [hsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hsp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  pending_points,
  output int                                  points_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsp_pkg::*;

  localparam longint TEMP_MAX = 64'sd2147483647;
  localparam longint TEMP_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           index;
    logic                       last;
  } grid_point_t;

  grid_point_t expected_points[$];

  logic signed [SAMPLE_W-1:0] temps [MAX_POINTS];
  logic [LEN_W-1:0]           len_reg;
  logic [STEP_W-1:0]          steps_reg;
  logic [COEFF_W-1:0]         coeff_reg;
  int unsigned                loaded;

  function automatic int unsigned ring_points(logic [LEN_W-1:0] len);
    if (len < MIN_POINTS) return MIN_POINTS;
    if (len > MAX_POINTS) return MAX_POINTS;
    return len;
  endfunction

  // One explicit update of a point from its two neighbors; the scaled
  // increment floors toward minus infinity and the sum saturates.
  function automatic logic signed [SAMPLE_W-1:0] relax_point(
      logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] mid,
      logic signed [SAMPLE_W-1:0] right, logic [COEFF_W-1:0] coeff);
    longint lap;
    longint incr;
    longint sum;
    lap  = longint'(left) + longint'(right) - 2 * longint'(mid);
    incr = (lap * longint'(coeff)) >>> 16;
    sum  = longint'(mid) + incr;
    if (sum > TEMP_MAX) return TEMP_MAX[SAMPLE_W-1:0];
    if (sum < TEMP_MIN) return TEMP_MIN[SAMPLE_W-1:0];
    return sum[SAMPLE_W-1:0];
  endfunction

  // Store a sample; on the one that fills the ring, run the steps and queue the grid.
  function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] sample);
    int unsigned n;
    logic signed [SAMPLE_W-1:0] nxt [MAX_POINTS];
    n = ring_points(len_reg);
    if (loaded >= MAX_POINTS) loaded = 0;
    temps[loaded] = sample;
    loaded++;
    if (loaded < n) return;
    for (int s = 0; s < int'(steps_reg); s++) begin
      for (int i = 0; i < n; i++)
        nxt[i] = relax_point(temps[(i == 0) ? n - 1 : i - 1], temps[i],
                             temps[(i + 1 == n) ? 0 : i + 1], coeff_reg);
      for (int i = 0; i < n; i++) temps[i] = nxt[i];
    end
    for (int i = 0; i < n; i++)
      expected_points.push_back('{temps[i], IDX_W'(i), i + 1 == n});
    loaded = 0;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_point();
    grid_point_t want;
    if (expected_points.size() == 0) begin
      report_error($sformatf("point %0d (value %h) with nothing pending",
                             dout.point_index, dout.value));
      return;
    end
    want = expected_points.pop_front();
    if (dout.value !== want.value)
      report_error($sformatf("point %0d value %h, want %h", want.index, dout.value,
                             want.value));
    if (dout.point_index !== want.index)
      report_error($sformatf("point_index %0d, want %0d", dout.point_index, want.index));
    if (dout.last !== want.last)
      report_error($sformatf("point %0d last %b, want %b", want.index, dout.last,
                             want.last));
    points_checked++;
  endtask

  // Samples accepted at an edge see the registers as they were before that edge.
  always @(posedge clk) begin
    if (rst) begin
      len_reg   = GRID_LENGTH_RST;
      steps_reg = STEP_COUNT_RST;
      coeff_reg = COEFF_RST;
      loaded    = 0;
      expected_points.delete();
    end else begin
      if (din.valid && din.ready) absorb_sample(din.sample);
      if (dout.valid && dout.ready) check_point();
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_LENGTH:     len_reg   = cfg_data[LEN_W-1:0];
          REG_STEP_COUNT:      steps_reg = cfg_data[STEP_W-1:0];
          REG_DIFFUSION_COEFF: coeff_reg = cfg_data[COEFF_W-1:0];
          default: ;
        endcase
      end
    end
    pending_points = expected_points.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the heat_stencil_1d_periodic testbench: clock, reset, register writes,
// sample stimulus and result pacing; hsp_ring_checker does the prediction.
// Depends on hsp_pkg, hsp_stream_if, heat_stencil_1d_periodic and hsp_ring_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsp_pkg::*;

  localparam int MAX_POINTS  = 64;
  localparam int ITEM_TARGET = 310;
  // Index 3 decodes to no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hsp_in_if  din ();
  hsp_out_if dout ();

  int fail_count;
  int pending_points;
  int points_checked;
  int samples_sent = 0;
  int phases_run   = 0;
  bit calm         = 1'b0;  // set near the end: no more idling on either side
  bit tx_jitter    = 1'b1;
  bit tx_on        = 1'b0;  // tracks the value last scheduled on din.valid

  heat_stencil_1d_periodic #(.MAX_POINTS(MAX_POINTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hsp_ring_checker #(.MAX_POINTS(MAX_POINTS)) checker_i (
    .clk            (clk),
    .rst            (rst),
    .din            (din),
    .dout           (dout),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_points (pending_points),
    .points_checked (points_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #30ms;
    $display("timeout with %0d points still pending", pending_points);
    $display("heat_stencil_1d_periodic: mismatch");
    $finish;
  end

  // Throttle the result side: random bursts of stalled cycles, switched on and off
  // in windows so some stretches run with ready held high.
  initial begin : result_pacing
    int burst;
    int cyc;
    bit jitter;
    burst  = 0;
    cyc    = 0;
    jitter = 1'b1;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 150 == 0) jitter = $urandom_range(0, 2) != 0;
      if (burst > 0) begin
        dout.ready <= 1'b0;
        burst--;
      end else if (!calm && jitter && $urandom_range(0, 5) == 0) begin
        dout.ready <= 1'b0;
        burst = $urandom_range(0, 10);
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  // Clamp a raw length the way the block does, to know how many samples fill a ring.
  function automatic int points_in(int len);
    if (len < MIN_POINTS) return MIN_POINTS;
    if (len > MAX_POINTS) return MAX_POINTS;
    return len;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style,
                                                            logic signed [SAMPLE_W-1:0] base);
    case (style)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0;
          3:       return -32'sh1;
          default: return 32'sh1;
        endcase
      end
      // smooth profile around a base value: small Laplacians
      2: return base + ($signed($urandom_range(0, 8192)) - 4096);
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  // Register write: a one-cycle enable pulse, then the enable is dropped before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_ring(input int len, input int steps, input int coeff);
    write_reg(REG_GRID_LENGTH, len);
    write_reg(REG_STEP_COUNT, steps);
    write_reg(REG_DIFFUSION_COEFF, coeff);
    phases_run++;
  endtask

  // Offer one sample and hold it until the transaction completes. A random gap
  // may go in front; valid stays high across back-to-back samples.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (!calm && tx_jitter && $urandom_range(0, 4) == 0) begin
      if (tx_on) din.valid <= 1'b0;
      tx_on = 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    din.valid  <= 1'b1;
    din.sample <= s;
    tx_on = 1'b1;
    do @(posedge clk); while (!din.ready);
    samples_sent++;
  endtask

  // Drop valid, wait for every pending point, then give a partly loaded ring
  // time to reach the block before any register changes.
  task automatic settle();
    if (tx_on) din.valid <= 1'b0;
    tx_on = 1'b0;
    do @(posedge clk); while (pending_points != 0);
    repeat (150) @(posedge clk);
  endtask

  initial begin : stimulus
    int len;
    int steps;
    int coeff;
    int n;
    int k;
    int style;
    logic signed [SAMPLE_W-1:0] base;

    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_GRID_LENGTH;
    cfg_data   <= '0;
    din.valid  <= 1'b0;
    din.sample <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero steps: the ring comes back unchanged; field extremes.
    program_ring(3, 0, 0);
    write_reg(REG_SPARE, 16'hFFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0);
    settle();

    // Full-scale coefficient on opposite extremes: saturation both ways.
    program_ring(3, 2, 65535);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    settle();

    // Length below the minimum clamps to three points; negative increments floor.
    program_ring(0, 1, 26214);
    send_sample(-32'sh1);
    send_sample(32'sh1);
    send_sample(32'sh0001_0000);
    settle();

    // Length shrunk during a load: the next sample completes the ring.
    program_ring(10, 3, 20000);
    for (int i = 0; i < 4; i++) send_sample(pick_sample(0, '0));
    settle();
    write_reg(REG_GRID_LENGTH, 2);
    send_sample(pick_sample(0, '0));
    settle();

    // Coefficient changed during a load: the completing sample's value rules.
    program_ring(5, 4, 1000);
    send_sample(pick_sample(3, '0));
    send_sample(pick_sample(3, '0));
    settle();
    write_reg(REG_DIFFUSION_COEFF, 50000);
    for (int i = 0; i < 3; i++) send_sample(pick_sample(3, '0));
    settle();

    // Longest step count on the shortest ring.
    program_ring(3, 65535, $urandom_range(0, 65535));
    for (int i = 0; i < 3; i++) send_sample(pick_sample(0, '0));
    settle();

    // Random phases: pick settings, then stream whole rings with random content.
    // Now and then break a ring with a register change in the middle of its load.
    for (int phase = 0; samples_sent < ITEM_TARGET; phase++) begin
      calm = samples_sent >= ITEM_TARGET - 40;
      if (phase == 0) begin
        len = 127;
      end else begin
        case ($urandom_range(0, 11))
          0:       len = $urandom_range(0, 2);
          1:       len = $urandom_range(65, 127);
          2:       len = 64;
          default: len = $urandom_range(3, 12);
        endcase
      end
      case ($urandom_range(0, 7))
        0:       steps = 0;
        1:       steps = $urandom_range(21, 300);
        default: steps = $urandom_range(1, 20);
      endcase
      case ($urandom_range(0, 7))
        0:       coeff = 0;
        1:       coeff = 65535;
        2:       coeff = 26214;
        default: coeff = $urandom_range(0, 65535);
      endcase
      settle();
      program_ring(len, steps, coeff);
      n = points_in(len);
      repeat ($urandom_range(1, 3)) begin
        tx_jitter = $urandom_range(0, 3) != 0;
        style     = $urandom_range(0, 3);
        base      = $urandom;
        if (!calm && n >= 4 && $urandom_range(0, 5) == 0) begin
          k = $urandom_range(3, n - 1);
          for (int i = 0; i < k; i++) send_sample(pick_sample(style, base));
          settle();
          if ($urandom_range(0, 1) == 0) begin
            // shrink to at most what is loaded: one more sample completes it
            len = $urandom_range(0, k);
            write_reg(REG_GRID_LENGTH, len);
            n = points_in(len);
            send_sample(pick_sample(style, base));
          end else begin
            write_reg(REG_DIFFUSION_COEFF, $urandom_range(0, 65535));
            for (int i = k; i < n; i++) send_sample(pick_sample(style, base));
          end
        end else begin
          for (int i = 0; i < n; i++) send_sample(pick_sample(style, base));
        end
      end
    end

    // Drain: wait for every pending point, then a quiet tail for strays.
    if (tx_on) din.valid <= 1'b0;
    tx_on = 1'b0;
    do @(posedge clk); while (pending_points != 0);
    repeat (300) @(posedge clk);

    $display("run covered %0d samples over %0d register settings, %0d points checked",
             samples_sent, phases_run, points_checked);
    $display("lengths clamped at both ends, steps 0..65535, coefficients 0..65535");
    if (fail_count == 0) begin
      $display("heat_stencil_1d_periodic: match");
    end else begin
      $display("heat_stencil_1d_periodic: mismatch");
    end
    $finish;
  end

endmodule

// ===== heat_stencil_1d_periodic.f =====
src/hsp_pkg.sv
src/hsp_stream_if.sv
src/hsp_ram.sv
src/hsp_front.sv
src/hsp_queue.sv
src/hsp_back.sv
src/heat_stencil_1d_periodic.sv
src/hsp_checker.sv
tb/sv/hsp_ring_checker.sv
tb/sv/tb_top.sv
